[sv/udr_pkg.sv]
// ----------------------------------------------------------------------------
// udr_pkg
// Shared types and constants for the unsigned divide/remainder unit.
// ----------------------------------------------------------------------------
package udr_pkg;

   // width of every operand and result field on the ports
   localparam int FIELD_W = 64;

   // default operand width used by the datapath
   localparam int DEFAULT_WIDTH = 64;

   typedef struct packed {
      logic [FIELD_W-1:0] dividend;
      logic [FIELD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] quotient;
      logic [FIELD_W-1:0] remainder;
      logic               zero_divisor;
   } rsp_type;

endpackage

[sv/unsigned_divide_remainder_unit.sv]
// ----------------------------------------------------------------------------
// unsigned_divide_remainder_unit
// Pipelined unsigned divider giving quotient and remainder of WIDTH-bit
// operands, one transaction per clock unless the output stalls.
// ----------------------------------------------------------------------------
// The unit takes one dividend/divisor pair per clock while req_ready is
// high and returns the quotient and remainder from the output register. An
// input register is followed by WIDTH restoring-division stages; each stage
// holds one WIDTH+1 bit subtract and produces one quotient bit, and the last
// stage is the output register. Operand bits above WIDTH are ignored and
// result bits above WIDTH read as zero. A zero divisor sets zero_divisor and
// returns an all-ones quotient with the dividend as remainder. A stalled
// result holds only the stages behind it that are full: empty stages still
// take new pairs, so the input keeps accepting while bubbles remain.
module unsigned_divide_remainder_unit #(
   parameter int WIDTH = udr_pkg::DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  udr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output udr_pkg::rsp_type rsp_data
);

   localparam int STAGES = WIDTH;

   // stage 0 is the input register, stage STAGES the output register
   logic             vld_ff  [0:STAGES];
   logic [WIDTH-1:0] rem_ff  [0:STAGES];
   logic [WIDTH-1:0] quo_ff  [0:STAGES];
   logic [WIDTH-1:0] den_ff  [0:STAGES];
   logic             zero_ff [0:STAGES];
   logic             adv     [0:STAGES];

   // a stage may load when it is empty or its content moves on
   assign adv[STAGES] = !vld_ff[STAGES] || rsp_ready;
   genvar g;
   generate
      for (g = 0; g < STAGES; g++) begin : g_adv
         assign adv[g] = !vld_ff[g] || adv[g+1];
      end
   endgenerate

   assign req_ready = adv[0];

   // input register
   logic [WIDTH-1:0] den_in;
   assign den_in = req_data.divisor[WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= req_data.dividend[WIDTH-1:0];
         den_ff[0]  <= den_in;
         zero_ff[0] <= (den_in == '0);
      end
   end

   // one quotient bit per stage; quo_ff shifts dividend bits out and
   // quotient bits in
   generate
      for (g = 0; g < STAGES; g++) begin : g_stage
         logic [WIDTH:0]   shifted;
         logic [WIDTH:0]   diff;
         logic [WIDTH-1:0] rem_in;
         logic [WIDTH-1:0] quo_in;

         always_comb begin
            shifted = {rem_ff[g], quo_ff[g][WIDTH-1]};
            diff    = shifted - {1'b0, den_ff[g]};
            if (!diff[WIDTH]) begin
               rem_in = diff[WIDTH-1:0];
               quo_in = {quo_ff[g][WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted[WIDTH-1:0];
               quo_in = {quo_ff[g][WIDTH-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g+1] <= 1'b0;
            end else if (adv[g+1]) begin
               vld_ff[g+1] <= vld_ff[g];
            end
         end

         always_ff @(posedge clock) begin
            if (adv[g+1]) begin
               rem_ff[g+1]  <= rem_in;
               quo_ff[g+1]  <= quo_in;
               den_ff[g+1]  <= den_ff[g];
               zero_ff[g+1] <= zero_ff[g];
            end
         end
      end
   endgenerate

   // zero divisor needs no special path: subtracting zero sets every
   // quotient bit and walks the dividend into the remainder
   assign rsp_valid              = vld_ff[STAGES];
   assign rsp_data.quotient      = udr_pkg::FIELD_W'(quo_ff[STAGES]);
   assign rsp_data.remainder     = udr_pkg::FIELD_W'(rem_ff[STAGES]);
   assign rsp_data.zero_divisor  = zero_ff[STAGES];

endmodule

[sv/udr_checker.sv]
// ----------------------------------------------------------------------------
// udr_checker
// Port-level checks for the unsigned divide/remainder unit.
// ----------------------------------------------------------------------------
module udr_checker #(
   parameter int WIDTH = udr_pkg::DEFAULT_WIDTH
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input udr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input udr_pkg::rsp_type rsp_data
);

   localparam logic [WIDTH-1:0] ALL_ONES = '1;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with nothing waiting at the output every stage can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_divisor |->
         rsp_data.quotient[WIDTH-1:0] == ALL_ONES)
      else $error("divide by zero without all-ones quotient");

   // all-ones quotient from a real divisor means divisor one, remainder zero
   a_full_quotient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_divisor
         && rsp_data.quotient[WIDTH-1:0] == ALL_ONES |->
         rsp_data.remainder == '0)
      else $error("all-ones quotient with nonzero remainder");

endmodule

bind unsigned_divide_remainder_unit udr_checker #(.WIDTH(WIDTH)) u_udr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
